// ===== sv/tccs_pkg.sv =====
package tccs_pkg;

  // Field widths of the word ports.
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int POS_W  = 13;
  localparam int CELL_W = 16;
  localparam int COLOR_W = 8;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Character and attribute constants.
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;

  typedef logic [CELL_W-1:0] cell_t;

endpackage

// ===== sv/text_console_cursor_scroll_top.sv =====
// Text-mode console: a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one single-port-write,
// registered-read memory, with a cursor that advances, wraps and scrolls.
// Every accepted word returns exactly one result word carrying the cursor and
// its linear position. After reset the block runs a clearing pass over every
// cell that fills the screen with 0x0F20; input stays stalled during it, and
// configuration writes are taken.
// A put or an on-screen read passes through accept, work and result steps;
// an off-screen read or the unused kind goes from accept straight to result.
// A put that moves past the bottom row adds a scroll: a copy pass that moves
// each row up, then a blanking pass whose first write is the last copied word
// and whose other writes blank the bottom row, since the copy moves one cell
// per cycle through the memory's single write port.
// A clear adds a fill pass over every cell for the same reason. A result
// waits in its register while the output is stalled, and the next word is
// taken then.
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tccs_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tccs_pkg::KIND_W-1:0]    kind,
  input  logic [tccs_pkg::CHAR_W-1:0]    char_code,
  input  logic [tccs_pkg::ROW_W-1:0]     cell_row,
  input  logic [tccs_pkg::COL_W-1:0]     cell_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tccs_pkg::CELL_W-1:0]    cell_value,
  output logic                           address_error,
  output logic [tccs_pkg::ROW_W-1:0]     cursor_row,
  output logic [tccs_pkg::COL_W-1:0]     cursor_col,
  output logic [tccs_pkg::POS_W-1:0]     cursor_position,
  output logic                           scrolled
);
  import tccs_pkg::*;

  localparam int NCELLS     = ROWS * COLUMNS;
  localparam int AW         = $clog2(NCELLS);
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  localparam logic [AW-1:0]    LAST_ADDR  = AW'(NCELLS - 1);
  localparam logic [AW-1:0]    COPY_LAST  = AW'(COPY_CELLS - 1);
  localparam logic [AW-1:0]    ROW_STRIDE = AW'(COLUMNS);
  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [POS_W-1:0] BOTTOM_POS = POS_W'(COPY_CELLS);
  localparam logic [POS_W-1:0] POS_STRIDE = POS_W'(COLUMNS);
  localparam cell_t            RESET_BLANK = {RESET_COLOR, CH_SPACE};

  // Sequencer states.
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_BLANK = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]         state;
  logic [AW-1:0]      idx;
  logic [COLOR_W-1:0] text_color;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [POS_W-1:0]   cur_pos;
  logic [CHAR_W-1:0]  op_char;
  cell_t              res_cell;
  logic               res_err;
  logic               res_scr;
  logic               cp_valid;
  logic [AW-1:0]      cp_addr;

  cell_t              mem [NCELLS];
  cell_t              rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  cell_t              wdata;
  logic [AW-1:0]      raddr;

  logic               accept;
  logic               row_adv;
  logic               rd_bad;
  logic [POS_W-1:0]   rd_lin;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Address of a read request and its range check.
  assign rd_bad = (cell_row > LAST_ROW) || (cell_col > LAST_COL);
  assign rd_lin = POS_W'(cell_row * COLUMNS) + POS_W'(cell_col);

  // The cursor leaves its row on a newline or on the last column.
  assign row_adv = (op_char == CH_NEWLINE) || (cur_col == LAST_COL);

  // Read port: the request address while idle, else the scroll source.
  assign raddr = (state == S_IDLE) ? rd_lin[AW-1:0] : idx + ROW_STRIDE;

  // Write port selection for each sequencer step.
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {text_color, CH_SPACE};
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = RESET_BLANK;
      end
      S_PUT: begin
        we    = (op_char != CH_NEWLINE);
        waddr = cur_pos[AW-1:0];
        wdata = {text_color, op_char};
      end
      S_CLEAR: begin
        we = 1'b1;
      end
      S_COPY: begin
        we    = cp_valid;
        waddr = cp_addr;
        wdata = rdata;
      end
      S_BLANK: begin
        we = 1'b1;
        if (cp_valid) begin
          waddr = cp_addr;
          wdata = rdata;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Screen memory with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Color register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_write) begin
      text_color <= cfg_data;
    end
  end

  // Sequencer, cursor and result capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      idx      <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      cur_pos  <= '0;
      cp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (idx == LAST_ADDR) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_char  <= char_code;
            res_cell <= '0;
            res_err  <= 1'b0;
            res_scr  <= 1'b0;
            case (kind)
              KIND_PUT: state <= S_PUT;
              KIND_READ: begin
                if (rd_bad) begin
                  res_err <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  state <= S_READ;
                end
              end
              KIND_CLEAR: begin
                idx     <= '0;
                cur_row <= '0;
                cur_col <= '0;
                cur_pos <= '0;
                state   <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_PUT: begin
          if (row_adv && cur_row == LAST_ROW) begin
            cur_row <= LAST_ROW;
            cur_col <= '0;
            cur_pos <= BOTTOM_POS;
            res_scr <= 1'b1;
            idx     <= '0;
            state   <= S_COPY;
          end else begin
            if (row_adv) begin
              cur_row <= cur_row + 1'b1;
              cur_col <= '0;
            end else begin
              cur_col <= cur_col + 1'b1;
            end
            if (op_char == CH_NEWLINE) begin
              cur_pos <= cur_pos - POS_W'(cur_col) + POS_STRIDE;
            end else begin
              cur_pos <= cur_pos + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_cell <= rdata;
          state    <= S_DONE;
        end
        S_CLEAR: begin
          if (idx == LAST_ADDR) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_COPY: begin
          // Each cycle reads one row ahead and writes the word read before.
          cp_valid <= 1'b1;
          cp_addr  <= idx;
          idx      <= idx + 1'b1;
          if (idx == COPY_LAST) begin
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (cp_valid) begin
            cp_valid <= 1'b0;
          end else if (idx == LAST_ADDR) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cell_value      <= res_cell;
      address_error   <= res_err;
      cursor_row      <= cur_row;
      cursor_col      <= cur_col;
      cursor_position <= cur_pos;
      scrolled        <= res_scr;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// One result word as the console reports it.
typedef struct packed {
  logic [tccs_pkg::CELL_W-1:0] value;
  logic                        err;
  logic [tccs_pkg::ROW_W-1:0]  row;
  logic [tccs_pkg::COL_W-1:0]  col;
  logic [tccs_pkg::POS_W-1:0]  pos;
  logic                        scr;
} console_result_t;

// Shadow of the screen, cursor and color that predicts every result word.
class console_scoreboard #(int COLUMNS = 80, int ROWS = 25);
  tccs_pkg::cell_t               screen [ROWS*COLUMNS];
  int unsigned                   cur_row;
  int unsigned                   cur_col;
  logic [tccs_pkg::COLOR_W-1:0]  color;
  console_result_t               expected_words [$];
  int                            errors;

  function new();
    color   = tccs_pkg::RESET_COLOR;
    cur_row = 0;
    cur_col = 0;
    errors  = 0;
    fill_screen();
  endfunction

  function void fill_screen();
    foreach (screen[i]) screen[i] = {color, tccs_pkg::CH_SPACE};
  endfunction

  // Move every row up one and blank the bottom row in the current color.
  function void scroll_up();
    for (int i = 0; i < (ROWS-1)*COLUMNS; i++) screen[i] = screen[i+COLUMNS];
    for (int i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++)
      screen[i] = {color, tccs_pkg::CH_SPACE};
  endfunction

  // Apply one accepted input word and queue the result it must produce.
  function void note_word(logic [tccs_pkg::KIND_W-1:0] k, logic [tccs_pkg::CHAR_W-1:0] ch,
                          logic [tccs_pkg::ROW_W-1:0] r, logic [tccs_pkg::COL_W-1:0] c);
    console_result_t res;
    int unsigned     lin;
    res = '0;
    case (k)
      tccs_pkg::KIND_PUT: begin
        if (ch == tccs_pkg::CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen[cur_row*COLUMNS + cur_col] = {color, ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          cur_row = ROWS - 1;
          scroll_up();
          res.scr = 1'b1;
        end
      end
      tccs_pkg::KIND_READ: begin
        if (r >= ROWS || c >= COLUMNS) res.err = 1'b1;
        else res.value = screen[r*COLUMNS + c];
      end
      tccs_pkg::KIND_CLEAR: begin
        fill_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    lin = cur_row*COLUMNS + cur_col;
    res.row = cur_row[tccs_pkg::ROW_W-1:0];
    res.col = cur_col[tccs_pkg::COL_W-1:0];
    res.pos = lin[tccs_pkg::POS_W-1:0];
    expected_words.push_back(res);
  endfunction

  function void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Compare one accepted result word with the oldest prediction.
  function void check_word(console_result_t act);
    console_result_t exp_w;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected: expected none, actual %h",
               $time, act);
      return;
    end
    exp_w = expected_words.pop_front();
    check_field("cell_value", 32'(exp_w.value), 32'(act.value));
    check_field("address_error", 32'(exp_w.err), 32'(act.err));
    check_field("cursor_row", 32'(exp_w.row), 32'(act.row));
    check_field("cursor_col", 32'(exp_w.col), 32'(act.col));
    check_field("cursor_position", 32'(exp_w.pos), 32'(act.pos));
    check_field("scrolled", 32'(exp_w.scr), 32'(act.scr));
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module tb_top;
  import tccs_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int LIMIT   = 20_000_000;
  localparam int PHASES  = 6;
  localparam int PHASE_WORDS = 325;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [COLOR_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   char_code;
  logic [ROW_W-1:0]    cell_row;
  logic [COL_W-1:0]    cell_col;
  logic                out_valid;
  logic                out_stall;
  logic [CELL_W-1:0]   cell_value;
  logic                address_error;
  logic [ROW_W-1:0]    cursor_row;
  logic [COL_W-1:0]    cursor_col;
  logic [POS_W-1:0]    cursor_position;
  logic                scrolled;

  console_scoreboard #(COLUMNS, ROWS) sb;
  int  cycle_count = 0;
  int  words_received = 0;
  int  burst_left = 0;
  bit  steady_sender = 0;
  bit  long_hold_done = 0;

  text_console_cursor_scroll_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .char_code(char_code),
    .cell_row(cell_row), .cell_col(cell_col), .out_valid(out_valid),
    .out_stall(out_stall), .cell_value(cell_value), .address_error(address_error),
    .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cursor_position(cursor_position), .scrolled(scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Observe both handshakes at the rising edge.
  always @(posedge clk) begin
    console_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_word(kind, char_code, cell_row, cell_col);
      if (out_valid && !out_stall) begin
        got.value = cell_value;
        got.err   = address_error;
        got.row   = cursor_row;
        got.col   = cursor_col;
        got.pos   = cursor_position;
        got.scr   = scrolled;
        words_received++;
        sb.check_word(got);
      end
    end
  end

  // Receiver stalls in segments of varying density, with one long hold so the
  // block backs up and stalls its input.
  initial begin
    int seg_len;
    int stall_pct;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_hold_done && words_received >= 300) begin
        long_hold_done = 1;
        out_stall = 1'b1;
        repeat (600) @(negedge clk);
      end
      seg_len = $urandom_range(10, 150);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (seg_len) begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
        @(negedge clk);
      end
    end
  end

  // Offer one word and hold it until accepted; called and returning at a
  // falling edge. Words go out in bursts with random gaps between them, none when the sender is steady.
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  = 1'b1;
    kind      = k;
    char_code = ch;
    cell_row  = r;
    cell_col  = c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly characters and newlines so the cursor reaches the bottom and
  // scrolls; reads cover the screen, with some off-screen addresses.
  task automatic send_random_word();
    int pick;
    logic [KIND_W-1:0] k;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    pick = $urandom_range(0, 99);
    ch = CHAR_W'($urandom_range(0, 255));
    r  = ROW_W'($urandom_range(0, 63));
    c  = COL_W'($urandom_range(0, 127));
    if (pick < 55) begin
      k = KIND_PUT;
    end else if (pick < 70) begin
      k  = KIND_PUT;
      ch = CH_NEWLINE;
    end else if (pick < 95) begin
      k = KIND_READ;
      if ($urandom_range(0, 4) != 0) begin
        r = ROW_W'(($urandom_range(0, 3) == 0) ? ROWS - 1 : $urandom_range(0, ROWS - 1));
        c = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 96) begin
      k = KIND_CLEAR;
    end else begin
      k = KIND_UNUSED;
    end
    send_word(k, ch, r, c);
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain();
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_text_color(input logic [COLOR_W-1:0] color);
    cfg_write = 1'b1;
    cfg_data  = color;
    sb.color  = color;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    logic [COLOR_W-1:0] color;
    sb        = new();
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = '0;
    char_code = '0;
    cell_row  = '0;
    cell_col  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset contents, off-screen reads, extreme characters, newline,
    // the unused kind and a clear, all in the reset color.
    send_word(KIND_READ, 8'h00, 6'd0, 7'd0);
    send_word(KIND_READ, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    send_word(KIND_READ, 8'h00, ROW_W'(ROWS), 7'd0);
    send_word(KIND_READ, 8'h00, 6'd0, COL_W'(COLUMNS));
    send_word(KIND_READ, 8'h00, 6'd63, 7'd127);
    send_word(KIND_PUT, 8'h41, 6'd63, 7'd127);
    send_word(KIND_PUT, 8'h00, 6'd0, 7'd0);
    send_word(KIND_PUT, 8'hFF, 6'd0, 7'd0);
    send_word(KIND_READ, 8'h00, 6'd0, 7'd0);
    send_word(KIND_READ, 8'h00, 6'd0, 7'd1);
    send_word(KIND_READ, 8'h00, 6'd0, 7'd2);
    send_word(KIND_PUT, CH_NEWLINE, 6'd0, 7'd0);
    send_word(KIND_PUT, 8'h7E, 6'd0, 7'd0);
    send_word(KIND_READ, 8'h00, 6'd1, 7'd0);
    send_word(KIND_UNUSED, 8'hFF, 6'd63, 7'd127);
    send_word(KIND_UNUSED, 8'h00, 6'd0, 7'd0);
    send_word(KIND_CLEAR, 8'hFF, 6'd63, 7'd127);
    send_word(KIND_READ, 8'h00, 6'd0, 7'd0);
    send_word(KIND_READ, 8'h00, 6'd1, 7'd0);
    drain();

    // Random phases, each under its own text color.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: color = 8'h00;
        1: color = 8'hFF;
        2: color = 8'h0E;
        5: color = 8'hA5;
        default: color = COLOR_W'($urandom_range(0, 255));
      endcase
      write_text_color(color);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 50 == 0) steady_sender = ($urandom_range(0, 2) == 0);
        send_random_word();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
